// ----- rtl/core/rttcw_pkg.sv -----
`default_nettype none
package rttcw_pkg;

  localparam int RTT_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int WIN_W      = 32;
  localparam int RTT_PORT_W = 32;
  localparam int GAIN_BITS  = 16;
  localparam int GROWTH_W   = 24;
  localparam int CEIL_W     = 16;
  localparam int START_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_BITS:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

  localparam logic [GAIN_BITS-1:0] SRTT_GAIN_RST   = 16'd8192;
  localparam logic [GAIN_BITS-1:0] VAR_GAIN_RST    = 16'd16384;
  localparam logic [GAIN_BITS-1:0] CUT_FACTOR_RST  = 16'd32768;
  localparam logic [GROWTH_W-1:0]  GROWTH_STEP_RST = 24'd65536;
  localparam logic [CEIL_W-1:0]    CEILING_RST     = 16'd0;
  localparam logic [START_W-1:0]   START_RST       = 15'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRTT_GAIN   = 3'd0,
    CFG_VAR_GAIN    = 3'd1,
    CFG_CUT_FACTOR  = 3'd2,
    CFG_GROWTH_STEP = 3'd3,
    CFG_CEILING     = 3'd4,
    CFG_START       = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_SLOW  = 2'd1,
    ACT_AVOID = 2'd2,
    ACT_CUT   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MUL_VAR_KEEP  = 3'd0,
    MUL_VAR_NEW   = 3'd1,
    MUL_SRTT_KEEP = 3'd2,
    MUL_SRTT_NEW  = 3'd3,
    MUL_CUT       = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] srtt_gain;
    logic [GAIN_BITS-1:0] variance_gain;
    logic [GAIN_BITS-1:0] window_cut_factor;
    logic [GROWTH_W-1:0]  window_growth_step;
    logic [CEIL_W-1:0]    window_ceiling;
    logic [START_W-1:0]   window_start;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     start;
    logic     first;
    logic     d_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     var_wr;
    logic     srtt_wr;
    logic     seen_inc;
    logic     cut_apply;
    logic     div_init;
    logic     div_step;
    logic     grow_slow;
    logic     grow_div;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic first;
    logic congest;
    logic slow;
    logic div_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/core/rttcw_ifs.sv -----
`default_nettype none
interface rttcw_req_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [rttcw_pkg::RTT_PORT_W-1:0]  rtt_sample_ns;

  modport source (output valid, opcode, rtt_sample_ns, input ready);
  modport sink   (input valid, opcode, rtt_sample_ns, output ready);
endinterface

interface rttcw_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rttcw_pkg::RTT_PORT_W-1:0]  smoothed_rtt_ns;
  logic [rttcw_pkg::RTT_PORT_W-1:0]  rtt_variance_ns;
  logic [rttcw_pkg::WIN_W-1:0]       cwnd;
  logic [rttcw_pkg::WIN_W-1:0]       slow_start_threshold;
  logic [1:0]                        window_action;

  modport source (output valid, smoothed_rtt_ns, rtt_variance_ns, cwnd,
                  slow_start_threshold, window_action, input ready);
  modport sink   (input valid, smoothed_rtt_ns, rtt_variance_ns, cwnd,
                  slow_start_threshold, window_action, output ready);
endinterface

interface rttcw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rttcw_pkg::CFG_IDX_W-1:0]   index;
  logic [rttcw_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rtt_estimator_congestion_window.sv -----
`default_nettype none
// RTT estimator and congestion window.
// req: one transfer per item, opcode 0 restarts the connection state, opcode 1
//   carries an RTT sample in ns. req.ready is high only while no item is in work.
// rsp: one transfer per item with srtt, variance, window, threshold and the action.
// cfg: register writes (index, data), always ready outside reset; write only idle.
// A start item goes straight to the output register. A first sample sets srtt and
//   variance and grows the window; a later sample runs the EWMA products first and
//   may cut the window. Congestion avoidance growth is set by the bit-serial divider
//   for growth_step / window.
// The four EWMA products share a 17 x max(RTT_BITS,WIN_W) multiplier, one per cycle.
// The block takes one item at a time; the next req is taken once the result sits in
// the output register, even while rsp is stalled. A finished item waits for a free
// output register before the block goes idle again.
// Reset (synchronous, active high) restores register defaults, clears the
// estimator, loads the default start window and drops rsp.valid.
module rtt_estimator_congestion_window #(
  parameter int RTT_BITS  = rttcw_pkg::RTT_BITS_DEF,
  parameter int FRAC_BITS = rttcw_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rttcw_req_if.sink   req,
  rttcw_rsp_if.source rsp,
  rttcw_cfg_if.sink   cfg
);

  rttcw_pkg::cfg_t    regs;
  rttcw_pkg::cmd_t    cmd;
  rttcw_pkg::status_t st;
  logic               in_ready;

  assign req.ready = in_ready;

  rttcw_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rttcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rttcw_datapath #(
    .RTT_BITS  (RTT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .cmd       (cmd),
    .st        (st),
    .in_opcode (req.opcode),
    .in_rtt    (req.rtt_sample_ns),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ----- rtl/core/rttcw_cfg.sv -----
`default_nettype none
module rttcw_cfg (
  input  wire logic      clk,
  input  wire logic      rst,
  rttcw_cfg_if.sink      cfg,
  output rttcw_pkg::cfg_t regs
);

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.srtt_gain          <= rttcw_pkg::SRTT_GAIN_RST;
      regs.variance_gain      <= rttcw_pkg::VAR_GAIN_RST;
      regs.window_cut_factor  <= rttcw_pkg::CUT_FACTOR_RST;
      regs.window_growth_step <= rttcw_pkg::GROWTH_STEP_RST;
      regs.window_ceiling     <= rttcw_pkg::CEILING_RST;
      regs.window_start       <= rttcw_pkg::START_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (rttcw_pkg::cfg_idx_t'(cfg.index))
        rttcw_pkg::CFG_SRTT_GAIN:   regs.srtt_gain <= cfg.data[rttcw_pkg::GAIN_BITS-1:0];
        rttcw_pkg::CFG_VAR_GAIN:    regs.variance_gain <= cfg.data[rttcw_pkg::GAIN_BITS-1:0];
        rttcw_pkg::CFG_CUT_FACTOR:  regs.window_cut_factor <=
                                      cfg.data[rttcw_pkg::GAIN_BITS-1:0];
        rttcw_pkg::CFG_GROWTH_STEP: regs.window_growth_step <=
                                      cfg.data[rttcw_pkg::GROWTH_W-1:0];
        rttcw_pkg::CFG_CEILING:     regs.window_ceiling <= cfg.data[rttcw_pkg::CEIL_W-1:0];
        rttcw_pkg::CFG_START:       regs.window_start <= cfg.data[rttcw_pkg::START_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rttcw_ctrl.sv -----
`default_nettype none
module rttcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rttcw_pkg::status_t st,
  output rttcw_pkg::cmd_t         cmd
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DISPATCH  = 11'b000_0000_0010,
    ST_VAR_NEW   = 11'b000_0000_0100,
    ST_SRTT_KEEP = 11'b000_0000_1000,
    ST_SRTT_NEW  = 11'b000_0001_0000,
    ST_SRTT_WR   = 11'b000_0010_0000,
    ST_CHECK     = 11'b000_0100_0000,
    ST_CUT       = 11'b000_1000_0000,
    ST_DIV       = 11'b001_0000_0000,
    ST_GROW      = 11'b010_0000_0000,
    ST_FINISH    = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!st.opcode) begin
          cmd.start  = 1'b1;
          state_next = ST_FINISH;
        end else if (st.first) begin
          cmd.first    = 1'b1;
          cmd.seen_inc = 1'b1;
          state_next   = ST_CHECK;
        end else begin
          cmd.d_en    = 1'b1;
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = rttcw_pkg::MUL_VAR_KEEP;
          state_next  = ST_VAR_NEW;
        end
      end
      ST_VAR_NEW: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = rttcw_pkg::MUL_VAR_NEW;
        cmd.acc_load = 1'b1;
        state_next   = ST_SRTT_KEEP;
      end
      ST_SRTT_KEEP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rttcw_pkg::MUL_SRTT_KEEP;
        cmd.var_wr  = 1'b1;
        state_next  = ST_SRTT_NEW;
      end
      ST_SRTT_NEW: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = rttcw_pkg::MUL_SRTT_NEW;
        cmd.acc_load = 1'b1;
        state_next   = ST_SRTT_WR;
      end
      ST_SRTT_WR: begin
        cmd.srtt_wr  = 1'b1;
        cmd.seen_inc = 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        if (st.congest) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = rttcw_pkg::MUL_CUT;
          state_next  = ST_CUT;
        end else if (st.slow) begin
          cmd.grow_slow = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_CUT: begin
        cmd.cut_apply = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_GROW;
        end
      end
      ST_GROW: begin
        cmd.grow_div = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/rttcw_datapath.sv -----
`default_nettype none
module rttcw_datapath #(
  parameter int RTT_BITS  = rttcw_pkg::RTT_BITS_DEF,
  parameter int FRAC_BITS = rttcw_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rttcw_pkg::cfg_t                  cfg,
  input  wire rttcw_pkg::cmd_t                  cmd,
  output rttcw_pkg::status_t                    st,
  input  wire logic                             in_opcode,
  input  wire logic [rttcw_pkg::RTT_PORT_W-1:0] in_rtt,
  rttcw_rsp_if.source                           rsp
);

  localparam int WIN_W  = rttcw_pkg::WIN_W;
  localparam int GB     = rttcw_pkg::GAIN_BITS;
  localparam int MW     = (RTT_BITS > WIN_W) ? RTT_BITS : WIN_W;
  localparam int PW     = GB + 1 + MW;
  localparam int LW     = RTT_BITS + 3;
  localparam int NW     = rttcw_pkg::GROWTH_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(NW);
  localparam int CAP_RAW = rttcw_pkg::CEIL_W + FRAC_BITS;
  localparam int CAP_W  = (CAP_RAW > WIN_W) ? CAP_RAW : WIN_W;
  localparam int SW_RAW = rttcw_pkg::START_W + 1 + FRAC_BITS;
  localparam int SW     = (SW_RAW > WIN_W) ? SW_RAW : WIN_W + 1;

  localparam logic [WIN_W-1:0] WIN_MAX = '1;
  localparam logic [WIN_W-1:0] FIX_ONE = {{(WIN_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [WIN_W-1:0] FLOOR2  = FIX_ONE << 1;

  function automatic logic [WIN_W-1:0] sat_win(input logic [SW-1:0] v);
    return (v > SW'(WIN_MAX)) ? WIN_MAX : v[WIN_W-1:0];
  endfunction

  localparam logic [WIN_W-1:0] RST_WIN = sat_win(SW'(rttcw_pkg::START_RST) << FRAC_BITS);
  localparam logic [WIN_W-1:0] RST_THR =
    sat_win(SW'(rttcw_pkg::START_RST) << (FRAC_BITS + 1));

  logic                      opcode_q;
  logic [RTT_BITS-1:0]       rtt_q;
  logic [RTT_BITS-1:0]       d_q;
  logic [RTT_BITS-1:0]       srtt;
  logic [RTT_BITS-1:0]       rtt_var;
  logic [WIN_W-1:0]          win;
  logic [WIN_W-1:0]          thr;
  logic [1:0]                seen;
  logic [PW-1:0]             prod;
  logic [PW-1:0]             acc;
  logic [NW-1:0]             div_num;
  logic [NW-1:0]             div_quo;
  logic [WIN_W-1:0]          div_rem;
  logic [CNT_W-1:0]          div_cnt;
  rttcw_pkg::action_t        action;

  logic                      out_valid;
  logic [rttcw_pkg::RTT_PORT_W-1:0] out_srtt;
  logic [rttcw_pkg::RTT_PORT_W-1:0] out_var;
  logic [WIN_W-1:0]          out_win;
  logic [WIN_W-1:0]          out_thr;
  rttcw_pkg::action_t        out_action;

  logic [GB:0]               mul_a;
  logic [MW-1:0]             mul_b;
  logic [PW-1:0]             mul_out;
  logic [PW:0]               mac_sum;
  logic [RTT_BITS-1:0]       d_next;
  logic [LW-1:0]             limit;
  logic [WIN_W-1:0]          cut_w;
  logic [WIN_W-1:0]          cut_thr;
  logic [WIN_W:0]            trial;
  logic                      ge;
  logic [WIN_W-1:0]          rem_next;
  logic [WIN_W-1:0]          inc;
  logic [WIN_W:0]            gsum;
  logic [WIN_W-1:0]          gsat;
  logic [CAP_W-1:0]          cap;
  logic [WIN_W-1:0]          grown;
  logic [SW-1:0]             start_win;
  logic [SW-1:0]             start_thr;

  always_comb begin
    case (cmd.mul_sel)
      rttcw_pkg::MUL_VAR_KEEP: begin
        mul_a = rttcw_pkg::GAIN_ONE - {1'b0, cfg.variance_gain};
        mul_b = MW'(rtt_var);
      end
      rttcw_pkg::MUL_VAR_NEW: begin
        mul_a = {1'b0, cfg.variance_gain};
        mul_b = MW'(d_q);
      end
      rttcw_pkg::MUL_SRTT_KEEP: begin
        mul_a = rttcw_pkg::GAIN_ONE - {1'b0, cfg.srtt_gain};
        mul_b = MW'(srtt);
      end
      rttcw_pkg::MUL_SRTT_NEW: begin
        mul_a = {1'b0, cfg.srtt_gain};
        mul_b = MW'(rtt_q);
      end
      rttcw_pkg::MUL_CUT: begin
        mul_a = {1'b0, cfg.window_cut_factor};
        mul_b = MW'(win);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;
  assign mac_sum = {1'b0, acc} + {1'b0, prod};
  assign d_next  = (rtt_q > srtt) ? rtt_q - srtt : srtt - rtt_q;
  assign limit   = LW'(srtt) + (LW'(rtt_var) << 2);

  assign cut_w   = WIN_W'(prod >> GB);
  assign cut_thr = (cut_w > FLOOR2) ? cut_w : FLOOR2;

  // restoring divider, one quotient bit per step; zero divisor yields all ones
  assign trial    = {div_rem, div_num[NW-1]};
  assign ge       = trial >= {1'b0, win};
  assign rem_next = ge ? WIN_W'(trial - {1'b0, win}) : trial[WIN_W-1:0];

  assign inc   = cmd.grow_slow ? FIX_ONE :
                 ((div_quo > NW'(WIN_MAX)) ? WIN_MAX : div_quo[WIN_W-1:0]);
  assign gsum  = {1'b0, win} + {1'b0, inc};
  assign gsat  = gsum[WIN_W] ? WIN_MAX : gsum[WIN_W-1:0];
  assign cap   = CAP_W'(cfg.window_ceiling) << FRAC_BITS;
  assign grown = ((cfg.window_ceiling != '0) && (CAP_W'(gsat) > cap)) ?
                 cap[WIN_W-1:0] : gsat;

  assign start_win = SW'(cfg.window_start) << FRAC_BITS;
  assign start_thr = SW'(cfg.window_start) << (FRAC_BITS + 1);

  assign st.opcode   = opcode_q;
  assign st.first    = (seen == 2'd0);
  assign st.congest  = (seen == 2'd2) && (LW'(rtt_q) > limit);
  assign st.slow     = win < thr;
  assign st.div_last = (div_cnt == '0);
  assign st.out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      opcode_q <= in_opcode;
      rtt_q    <= RTT_BITS'(in_rtt);
    end
    if (cmd.d_en) begin
      d_q <= d_next;
    end
    if (cmd.mul_en) begin
      prod <= mul_out;
    end
    if (cmd.acc_load) begin
      acc <= prod;
    end
    if (cmd.div_init) begin
      div_num <= {cfg.window_growth_step, {FRAC_BITS{1'b0}}};
      div_rem <= '0;
      div_cnt <= CNT_W'(NW - 1);
    end else if (cmd.div_step) begin
      div_num <= div_num << 1;
      div_rem <= rem_next;
      div_quo <= {div_quo[NW-2:0], ge};
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.publish) begin
      out_srtt   <= rttcw_pkg::RTT_PORT_W'(srtt);
      out_var    <= rttcw_pkg::RTT_PORT_W'(rtt_var);
      out_win    <= win;
      out_thr    <= thr;
      out_action <= action;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srtt      <= '0;
      rtt_var   <= '0;
      win       <= RST_WIN;
      thr       <= RST_THR;
      seen      <= 2'd0;
      action    <= rttcw_pkg::ACT_START;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        srtt    <= '0;
        rtt_var <= '0;
        seen    <= 2'd0;
        win     <= sat_win(start_win);
        thr     <= sat_win(start_thr);
        action  <= rttcw_pkg::ACT_START;
      end
      if (cmd.first) begin
        srtt    <= rtt_q;
        rtt_var <= rtt_q >> 1;
      end
      if (cmd.var_wr) begin
        rtt_var <= RTT_BITS'(mac_sum >> GB);
      end
      if (cmd.srtt_wr) begin
        srtt <= RTT_BITS'(mac_sum >> GB);
      end
      if (cmd.seen_inc && seen != 2'd2) begin
        seen <= seen + 2'd1;
      end
      if (cmd.cut_apply) begin
        thr    <= cut_thr;
        win    <= cut_thr;
        action <= rttcw_pkg::ACT_CUT;
      end
      if (cmd.grow_slow) begin
        win    <= grown;
        action <= rttcw_pkg::ACT_SLOW;
      end
      if (cmd.grow_div) begin
        win    <= grown;
        action <= rttcw_pkg::ACT_AVOID;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid                = out_valid;
  assign rsp.smoothed_rtt_ns      = out_srtt;
  assign rsp.rtt_variance_ns      = out_var;
  assign rsp.cwnd                 = out_win;
  assign rsp.slow_start_threshold = out_thr;
  assign rsp.window_action        = out_action;

endmodule
`default_nettype wire

// ----- rtl/core/rttcw_checker.sv -----
`default_nettype none
module rttcw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] rsp_srtt,
  input wire logic [31:0] rsp_var,
  input wire logic [31:0] rsp_win,
  input wire logic [31:0] rsp_thr,
  input wire logic [1:0]  rsp_action
);

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req taken while an item is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp dropped before transfer");

  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_action == rttcw_pkg::ACT_START) |-> rsp_srtt == '0 && rsp_var == '0)
    else $error("start result with nonzero estimator");

  a_cut_equal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_action == rttcw_pkg::ACT_CUT) |-> rsp_win == rsp_thr)
    else $error("cut result with window unequal to threshold");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid after reset");

endmodule

bind rtt_estimator_congestion_window rttcw_checker u_rttcw_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_srtt   (rsp.smoothed_rtt_ns),
  .rsp_var    (rsp.rtt_variance_ns),
  .rsp_win    (rsp.cwnd),
  .rsp_thr    (rsp.slow_start_threshold),
  .rsp_action (rsp.window_action)
);
`default_nettype wire

// ----- verif/tb_rtt_estimator_congestion_window.sv -----
`default_nettype none
module tb_rtt_estimator_congestion_window;
  timeunit 1ns;
  timeprecision 1ps;

  import rttcw_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic [63:0] WIN_TOP = 64'hFFFF_FFFF;
  localparam logic [63:0] FIX_UNIT = 64'd1 << FRAC;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int ITEM_TARGET = 900;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_CAP = 30;

  typedef struct packed {
    logic [31:0] srtt;
    logic [31:0] rttvar;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    action_t     action;
  } cw_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   op;
    logic [31:0]            rtt;
    logic                   typed;
    cw_result_t             want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rttcw_req_if req();
  rttcw_rsp_if rsp();
  rttcw_cfg_if cfg();

  rtt_estimator_congestion_window DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow registers and estimator state
  logic [15:0] alpha, beta, cut_factor, ceiling;
  logic [23:0] growth;
  logic [14:0] start_segs;
  logic [31:0] srtt_est, var_est, win_est, thr_est;
  logic [1:0]  samples;

  cw_result_t  expected_results[$];
  script_row_t script[$];

  logic        typed_pending = 1'b0;
  cw_result_t  typed_result = '0;
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_done = 1'b0;

  function automatic logic [31:0] clip_window(logic [63:0] v);
    return (v > WIN_TOP) ? WIN_TOP[31:0] : v[31:0];
  endfunction

  function automatic void restart_connection();
    win_est = clip_window(64'(start_segs) << FRAC);
    thr_est = clip_window((64'(start_segs) * 64'd2) << FRAC);
    srtt_est = '0;
    var_est = '0;
    samples = '0;
  endfunction

  function automatic cw_result_t advance_estimator(logic op, logic [31:0] rtt);
    logic [63:0] r, s, v, d, lim, cut, inc, cap, w;
    cw_result_t res;
    res = '0;
    if (!op) begin
      restart_connection();
      res.action = ACT_START;
    end else begin
      r = 64'(rtt);
      s = 64'(srtt_est);
      v = 64'(var_est);
      if (samples == 2'd0) begin
        s = r;
        v = r >> 1;
      end else begin
        // variance uses the srtt from before this sample
        d = (r > s) ? r - s : s - r;
        v = ((64'(GAIN_ONE) - 64'(beta)) * v + 64'(beta) * d) >> GAIN_BITS;
        s = ((64'(GAIN_ONE) - 64'(alpha)) * s + 64'(alpha) * r) >> GAIN_BITS;
      end
      if (samples < 2'd2) samples = samples + 2'd1;
      srtt_est = s[31:0];
      var_est = v[31:0];
      lim = s + 64'd4 * v;
      w = 64'(win_est);
      if (samples > 2'd1 && r > lim) begin
        cut = (w * 64'(cut_factor)) >> GAIN_BITS;
        thr_est = clip_window((cut > 64'd2 * FIX_UNIT) ? cut : 64'd2 * FIX_UNIT);
        win_est = thr_est;
        res.action = ACT_CUT;
      end else begin
        if (win_est < thr_est) begin
          inc = FIX_UNIT;
          res.action = ACT_SLOW;
        end else begin
          inc = (win_est == '0) ? WIN_TOP : (64'(growth) << FRAC) / w;
          res.action = ACT_AVOID;
        end
        if (inc > WIN_TOP) inc = WIN_TOP;
        win_est = clip_window(w + inc);
        cap = 64'(ceiling) << FRAC;
        if (ceiling != '0 && 64'(win_est) > cap) win_est = cap[31:0];
      end
    end
    res.srtt = srtt_est;
    res.rttvar = var_est;
    res.cwnd = win_est;
    res.ssthresh = thr_est;
    return res;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] seen,
                               input logic [31:0] wanted);
    if (errors < PRINT_CAP)
      $display("%0t: %s got %h want %h", $realtime, field, seen, wanted);
    errors++;
  endtask

  always @(posedge clk) begin : scoreboard
    cw_result_t want, seen;
    if (rst) begin
      alpha = SRTT_GAIN_RST;
      beta = VAR_GAIN_RST;
      cut_factor = CUT_FACTOR_RST;
      growth = GROWTH_STEP_RST;
      ceiling = CEILING_RST;
      start_segs = START_RST;
      restart_connection();
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SRTT_GAIN:   alpha = cfg.data[15:0];
          CFG_VAR_GAIN:    beta = cfg.data[15:0];
          CFG_CUT_FACTOR:  cut_factor = cfg.data[15:0];
          CFG_GROWTH_STEP: growth = cfg.data[23:0];
          CFG_CEILING:     ceiling = cfg.data[15:0];
          CFG_START:       start_segs = cfg.data[14:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing outstanding", rsp.smoothed_rtt_ns, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.smoothed_rtt_ns !== want.srtt)
            note_mismatch("smoothed_rtt_ns", rsp.smoothed_rtt_ns, want.srtt);
          if (rsp.rtt_variance_ns !== want.rttvar)
            note_mismatch("rtt_variance_ns", rsp.rtt_variance_ns, want.rttvar);
          if (rsp.cwnd !== want.cwnd)
            note_mismatch("cwnd", rsp.cwnd, want.cwnd);
          if (rsp.slow_start_threshold !== want.ssthresh)
            note_mismatch("slow_start_threshold", rsp.slow_start_threshold, want.ssthresh);
          if (rsp.window_action !== want.action)
            note_mismatch("window_action", 32'(rsp.window_action), 32'(want.action));
        end
      end
      if (req.valid && req.ready) begin
        seen = advance_estimator(req.opcode, req.rtt_sample_ns);
        expected_results.push_back(typed_pending ? typed_result : seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("rtt_estimator_congestion_window: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : receiver
    int stall, phase_left;
    rsp.ready = 1'b0;
    phase_left = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      // long hold-off while the sender keeps offering, so the input backs up
      if (!hold_done && results_seen >= HOLD_AT && req.valid) begin
        hold_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (phase_left == 0) begin
        rx_steady = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(100, 300);
      end
      phase_left--;
      stall = rx_steady ? 0 : pick_gap();
      if (stall == 0) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    script_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    script.push_back(row);
  endfunction

  function automatic void add_item(logic op, logic [31:0] rtt);
    script_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.rtt = rtt;
    script.push_back(row);
  endfunction

  function automatic void add_known(logic op, logic [31:0] rtt, cw_result_t want);
    script_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.rtt = rtt;
    row.typed = 1'b1;
    row.want = want;
    script.push_back(row);
  endfunction

  task automatic offer(logic op, logic [31:0] rtt, logic typed, cw_result_t want);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.opcode <= op;
    req.rtt_sample_ns <= rtt;
    typed_pending = typed;
    typed_result = want;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // new register set; bits above the narrower registers' widths carry junk
  task automatic retune();
    logic [23:0] grow_val;
    logic [15:0] ceil_val;
    logic [14:0] start_val;
    drain();
    case ($urandom_range(0, 5))
      0: grow_val = 24'h000000;
      1: grow_val = 24'hFFFFFF;
      2: grow_val = 24'h010000;
      default: grow_val = 24'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1: ceil_val = 16'($urandom_range(1, 64));
      2: ceil_val = 16'hFFFF;
      3: ceil_val = 16'($urandom);
      default: ceil_val = 16'h0000;
    endcase
    case ($urandom_range(0, 9))
      0: start_val = 15'h0000;
      1: start_val = 15'h7FFF;
      2: start_val = 15'($urandom);
      default: start_val = 15'($urandom_range(1, 16));
    endcase
    write_reg(CFG_SRTT_GAIN, {8'($urandom), pick_gain()});
    write_reg(CFG_VAR_GAIN, {8'($urandom), pick_gain()});
    write_reg(CFG_CUT_FACTOR, {8'($urandom), pick_gain()});
    write_reg(CFG_GROWTH_STEP, grow_val);
    write_reg(CFG_CEILING, {8'($urandom), ceil_val});
    write_reg(CFG_START, {9'($urandom), start_val});
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 24'($urandom));
    tx_steady = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [31:0] clip_rtt(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  initial begin : stimulus
    logic [31:0] base, sample;
    logic [63:0] spread;
    int len, roll, next_retune;

    req.valid = 1'b0;
    req.opcode = 1'b0;
    req.rtt_sample_ns = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;

    // defaults: start, extreme first sample, growth into avoidance, spike
    add_known(1'b0, 32'h0, cw_result_t'{32'd0, 32'd0, 32'h0004_0000, 32'h0008_0000, ACT_START});
    add_known(1'b1, 32'hFFFF_FFFF,
              cw_result_t'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0005_0000, 32'h0008_0000,
                           ACT_SLOW});
    add_known(1'b0, 32'hFFFF_FFFF,
              cw_result_t'{32'd0, 32'd0, 32'h0004_0000, 32'h0008_0000, ACT_START});
    add_known(1'b1, 32'd1000,
              cw_result_t'{32'd1000, 32'd500, 32'h0005_0000, 32'h0008_0000, ACT_SLOW});
    repeat (4) add_item(1'b1, 32'd1000);
    add_item(1'b1, 32'hFFFF_FFFF);
    // zero start window: avoidance with a zero divisor saturates
    add_write(CFG_START, 24'h000000);
    add_known(1'b0, 32'h0, cw_result_t'{32'd0, 32'd0, 32'd0, 32'd0, ACT_START});
    add_known(1'b1, 32'd5,
              cw_result_t'{32'd5, 32'd2, 32'hFFFF_FFFF, 32'd0, ACT_AVOID});
    // same, limited by a one-segment ceiling
    add_write(CFG_CEILING, 24'h000001);
    add_known(1'b0, 32'h0, cw_result_t'{32'd0, 32'd0, 32'd0, 32'd0, ACT_START});
    add_known(1'b1, 32'd7,
              cw_result_t'{32'd7, 32'd3, 32'h0001_0000, 32'd0, ACT_AVOID});
    // largest start window; ceiling cleared through masked upper bits
    add_write(CFG_CEILING, 24'hFF0000);
    add_write(CFG_START, 24'h007FFF);
    add_known(1'b0, 32'h0,
              cw_result_t'{32'd0, 32'd0, 32'h7FFF_0000, 32'hFFFE_0000, ACT_START});
    add_known(1'b1, 32'h0,
              cw_result_t'{32'd0, 32'd0, 32'h8000_0000, 32'hFFFE_0000, ACT_SLOW});
    add_item(1'b1, 32'hFFFF_FFFF);
    // zero gains and cut factor, largest growth step, unused indexes
    add_write(CFG_SRTT_GAIN, 24'h000000);
    add_write(CFG_VAR_GAIN, 24'h000000);
    add_write(CFG_CUT_FACTOR, 24'h000000);
    add_write(CFG_GROWTH_STEP, 24'hFFFFFF);
    add_write(CFG_START, 24'hFF8003);
    add_write(CFG_SPARE_LO, 24'hA5A5A5);
    add_write(CFG_SPARE_HI, 24'h5A5A5A);
    add_known(1'b0, 32'h0,
              cw_result_t'{32'd0, 32'd0, 32'h0003_0000, 32'h0006_0000, ACT_START});
    add_known(1'b1, 32'd100,
              cw_result_t'{32'd100, 32'd50, 32'h0004_0000, 32'h0006_0000, ACT_SLOW});
    add_item(1'b1, 32'd100);
    add_item(1'b1, 32'h1000_0000);
    add_item(1'b1, 32'd100);
    // full gains, zero growth step, widest ceiling
    add_write(CFG_SRTT_GAIN, 24'h00FFFF);
    add_write(CFG_VAR_GAIN, 24'h00FFFF);
    add_write(CFG_CUT_FACTOR, 24'h00FFFF);
    add_write(CFG_GROWTH_STEP, 24'h000000);
    add_write(CFG_CEILING, 24'h00FFFF);
    add_write(CFG_START, 24'h000004);
    add_item(1'b0, 32'h0);
    add_item(1'b1, 32'd200);
    add_item(1'b1, 32'hFFFF_FFFF);
    add_item(1'b1, 32'd250);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain();
        write_reg(script[i].idx, script[i].data);
      end else begin
        offer(script[i].op, script[i].rtt, script[i].typed, script[i].want);
      end
    end

    next_retune = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_retune) begin
        retune();
        next_retune = items_sent + $urandom_range(80, 160);
      end
      if ($urandom_range(0, 9) == 0) begin
        offer(1'($urandom_range(0, 1)), 32'($urandom), 1'b0, '0);
      end else begin
        if ($urandom_range(0, 9) != 0) offer(1'b0, 32'($urandom), 1'b0, '0);
        case ($urandom_range(0, 3))
          0: base = 32'($urandom_range(1, 2000));
          1: base = 32'($urandom_range(10000, 2000000));
          2: base = 32'($urandom);
          default: base = 32'($urandom_range(0, 50));
        endcase
        len = $urandom_range(2, 24);
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            sample = clip_rtt(64'(base) * 64'($urandom_range(3, 12)) +
                              64'($urandom_range(1, 1000)));
          end else if (roll < 12) begin
            sample = 32'($urandom);
          end else begin
            spread = 64'(base) >> 3;
            sample = clip_rtt(64'(base) - spread +
                              64'($urandom_range(0, 32'(spread * 64'd2))));
          end
          offer(1'b1, sample, 1'b0, '0);
        end
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("rtt_estimator_congestion_window: match");
    end else begin
      $display("rtt_estimator_congestion_window: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- rtt_estimator_congestion_window.f -----
rtl/core/rttcw_pkg.sv
rtl/core/rttcw_ifs.sv
rtl/core/rttcw_cfg.sv
rtl/core/rttcw_ctrl.sv
rtl/core/rttcw_datapath.sv
rtl/core/rtt_estimator_congestion_window.sv
rtl/core/rttcw_checker.sv
verif/tb_rtt_estimator_congestion_window.sv
